### hw/rtl/ang_pkg.sv
// shared types, constants and helpers of the audio noise gate
package ang_pkg;

    // field and arithmetic widths
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 24;
    localparam int COEF_REG_BITS  = COEF_BITS + 1;
    localparam int PROD_BITS      = 2 * COEF_REG_BITS;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = COEF_REG_BITS;

    typedef logic signed [SAMPLE_BITS-1:0]   sample_t;
    typedef logic        [SAMPLE_BITS-1:0]   mag_t;
    typedef logic        [COEF_BITS-1:0]     gain_t;
    typedef logic        [COEF_REG_BITS-1:0] coef_t;
    typedef logic        [PROD_BITS-1:0]     prod_t;
    typedef logic        [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic        [CFG_DATA_BITS-1:0]  cfg_data_t;

    // unity in Q1.24 and the rounding offset for ceiling products
    localparam coef_t UNITY      = coef_t'(1) << COEF_BITS;
    localparam prod_t ROUND_UP   = prod_t'(UNITY) - prod_t'(1);
    localparam gain_t GAIN_MAX   = {COEF_BITS{1'b1}};

    // register indexes
    localparam cfg_index_t CFG_THRESHOLD = cfg_index_t'(0);
    localparam cfg_index_t CFG_ATTACK    = cfg_index_t'(1);
    localparam cfg_index_t CFG_RELEASE   = cfg_index_t'(2);
    localparam cfg_index_t CFG_DETECTOR  = cfg_index_t'(3);

    // register reset values
    localparam mag_t  THRESHOLD_RST = mag_t'(8389);
    localparam coef_t ATTACK_RST    = coef_t'(69760);
    localparam coef_t RELEASE_RST   = coef_t'(3495);
    localparam coef_t DETECTOR_RST  = coef_t'(34915);

    // current register contents, coefficients already limited to unity
    typedef struct packed {
        mag_t  threshold_level;
        coef_t attack_coef;
        coef_t release_coef;
        coef_t detector_coef;
    } ang_cfg_t;

    // one request to the shared multiplier
    typedef struct packed {
        coef_t op_a;
        coef_t op_c;
        logic  round_up;
    } ang_mul_req_t;

    // coefficient above unity acts as unity
    function automatic coef_t clamp_coef(input coef_t c);
        coef_t r;
        r = (c > UNITY) ? UNITY : c;
        return r;
    endfunction

endpackage

### hw/rtl/ang_if.sv
// handshake channels of the audio noise gate

// input sample channel
interface ang_in_if;
    logic             valid;
    logic             ready;
    ang_pkg::sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// gated sample channel
interface ang_out_if;
    logic             valid;
    logic             ready;
    ang_pkg::sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

// register write channel
interface ang_cfg_if;
    logic                valid;
    logic                ready;
    ang_pkg::cfg_index_t index;
    ang_pkg::cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/audio_noise_gate.sv
// audio noise gate top level: sequencer around one shared multiplier
//
// Usage:
//   sample_ch  takes one signed Q1.23 sample per transfer (valid/ready).
//   result_ch  gives the gated sample for each input, in order, one transfer each.
//   cfg_ch     writes threshold, attack, release and detector registers by index
//              0..3; other indexes are dropped. Write only while the gate is idle.
// Sequence:
//   one multiplier serves three products per sample: envelope decay, gain step
//   and output scaling. Each has an issue state and a write-back state, and a
//   new sample is taken only once the sequencer is back in idle after the last
//   write-back. sample_ch.ready is high only while the sequencer is idle.
// Stall:
//   the result waits in an output register; the next sample is still taken,
//   and its result is held back in the last step until the register is free.
// Reset:
//   rst_n clears the envelope and the gain (gate closed), loads the register
//   defaults and empties the output register. No clearing pass is needed.
module audio_noise_gate (
    input  logic      clk,
    input  logic      rst_n,
    ang_in_if.sink    sample_ch,
    ang_out_if.source result_ch,
    ang_cfg_if.sink   cfg_ch
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENV,
        S_ENV_WB,
        S_GAIN,
        S_GAIN_WB,
        S_OUT,
        S_OUT_WB
    } state_t;

    state_t                state_reg;
    ang_pkg::mag_t         mag_reg;
    logic                  neg_reg;
    ang_pkg::mag_t         env_reg;
    ang_pkg::gain_t        gain_reg;
    logic                  open_reg;
    logic                  out_valid_reg;
    ang_pkg::sample_t      out_sample_reg;

    ang_pkg::ang_cfg_t     cfg;
    ang_pkg::ang_mul_req_t mul_req;
    ang_pkg::coef_t        mul_q;

    ang_pkg::mag_t         mag_next;
    ang_pkg::mag_t         env_next;
    ang_pkg::gain_t        gain_next;
    ang_pkg::coef_t        gain_sum;
    ang_pkg::sample_t      out_next;
    logic                  in_fire;
    logic                  out_free;

    ang_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    ang_mul u_mul (
        .clk   (clk),
        .req   (mul_req),
        .q_reg (mul_q)
    );

    // handshakes
    assign sample_ch.ready      = (state_reg == S_IDLE);
    assign in_fire              = sample_ch.valid && sample_ch.ready;
    assign out_free             = !out_valid_reg || result_ch.ready;
    assign result_ch.valid      = out_valid_reg;
    assign result_ch.sample_out = out_sample_reg;

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_req = '0;
        unique case (state_reg)
            S_ENV:
            begin
                mul_req.op_a     = ang_pkg::coef_t'(env_reg - mag_reg);
                mul_req.op_c     = cfg.detector_coef;
                mul_req.round_up = 1'b1;
            end
            S_GAIN:
            begin
                if (open_reg)
                begin
                    mul_req.op_a     = ang_pkg::UNITY - ang_pkg::coef_t'(gain_reg);
                    mul_req.op_c     = cfg.attack_coef;
                    mul_req.round_up = 1'b0;
                end
                else
                begin
                    mul_req.op_a     = ang_pkg::coef_t'(gain_reg);
                    mul_req.op_c     = cfg.release_coef;
                    mul_req.round_up = 1'b1;
                end
            end
            // operands stay put while the result waits for the output register
            S_OUT, S_OUT_WB:
            begin
                mul_req.op_a     = ang_pkg::coef_t'(mag_reg);
                mul_req.op_c     = ang_pkg::coef_t'(gain_reg);
                mul_req.round_up = neg_reg;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // write-back values from the multiplier result
    always_comb
    begin
        mag_next = sample_ch.sample_in[ang_pkg::SAMPLE_BITS-1]
                 ? ang_pkg::mag_t'(-sample_ch.sample_in)
                 : ang_pkg::mag_t'(sample_ch.sample_in);
        // peak jumps up, otherwise decay toward the magnitude
        env_next = (mag_reg > env_reg)
                 ? mag_reg
                 : env_reg - mul_q[ang_pkg::SAMPLE_BITS-1:0];
        // attack saturates one step below unity, release steps down
        gain_sum = ang_pkg::coef_t'(gain_reg) + mul_q;
        if (open_reg)
        begin
            gain_next = gain_sum[ang_pkg::COEF_BITS]
                      ? ang_pkg::GAIN_MAX
                      : gain_sum[ang_pkg::COEF_BITS-1:0];
        end
        else
        begin
            gain_next = gain_reg - mul_q[ang_pkg::COEF_BITS-1:0];
        end
        // negative samples use the ceiling of the magnitude product
        out_next = neg_reg
                 ? -ang_pkg::sample_t'(mul_q[ang_pkg::SAMPLE_BITS-1:0])
                 : ang_pkg::sample_t'(mul_q[ang_pkg::SAMPLE_BITS-1:0]);
    end

    // sequencer with its state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            env_reg        <= '0;
            gain_reg       <= '0;
            open_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
        end
        else
        begin
            // the final step reloads the output register itself
            if (out_valid_reg && result_ch.ready && (state_reg != S_OUT_WB))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        mag_reg   <= mag_next;
                        neg_reg   <= sample_ch.sample_in[ang_pkg::SAMPLE_BITS-1];
                        state_reg <= S_ENV;
                    end
                end
                S_ENV:
                begin
                    state_reg <= S_ENV_WB;
                end
                S_ENV_WB:
                begin
                    env_reg   <= env_next;
                    open_reg  <= (env_next >= cfg.threshold_level);
                    state_reg <= S_GAIN;
                end
                S_GAIN:
                begin
                    state_reg <= S_GAIN_WB;
                end
                S_GAIN_WB:
                begin
                    gain_reg  <= gain_next;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    state_reg <= S_OUT_WB;
                end
                S_OUT_WB:
                begin
                    if (out_free)
                    begin
                        out_sample_reg <= out_next;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/ang_cfg.sv
// configuration registers of the audio noise gate
module ang_cfg (
    input  logic              clk,
    input  logic              rst_n,
    ang_cfg_if.sink           cfg_ch,
    output ang_pkg::ang_cfg_t cfg
);

    ang_pkg::ang_cfg_t cfg_reg;
    logic              wr_en;

    // writes are always taken
    assign cfg_ch.ready = 1'b1;
    assign wr_en        = cfg_ch.valid;
    assign cfg          = cfg_reg;

    // register file, coefficients limited to unity on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_level <= ang_pkg::THRESHOLD_RST;
            cfg_reg.attack_coef     <= ang_pkg::ATTACK_RST;
            cfg_reg.release_coef    <= ang_pkg::RELEASE_RST;
            cfg_reg.detector_coef   <= ang_pkg::DETECTOR_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_ch.index)
                ang_pkg::CFG_THRESHOLD:
                    cfg_reg.threshold_level <= cfg_ch.data[ang_pkg::SAMPLE_BITS-1:0];
                ang_pkg::CFG_ATTACK:
                    cfg_reg.attack_coef <= ang_pkg::clamp_coef(cfg_ch.data);
                ang_pkg::CFG_RELEASE:
                    cfg_reg.release_coef <= ang_pkg::clamp_coef(cfg_ch.data);
                ang_pkg::CFG_DETECTOR:
                    cfg_reg.detector_coef <= ang_pkg::clamp_coef(cfg_ch.data);
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

endmodule

### hw/rtl/ang_mul.sv
// shared multiplier: registered floor or ceiling of a * c / 2^24
module ang_mul (
    input  logic                  clk,
    input  ang_pkg::ang_mul_req_t req,
    output ang_pkg::coef_t        q_reg
);

    ang_pkg::prod_t prod;
    ang_pkg::prod_t sum;
    ang_pkg::coef_t q_next;

    // product, optional ceiling offset, drop the fraction
    always_comb
    begin
        prod   = ang_pkg::prod_t'(req.op_a) * ang_pkg::prod_t'(req.op_c);
        sum    = prod + (req.round_up ? ang_pkg::ROUND_UP : '0);
        q_next = sum[ang_pkg::COEF_BITS +: ang_pkg::COEF_REG_BITS];
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

### hw/rtl/ang_checker.sv
// port-level checks of the audio noise gate and their binding
module ang_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input ang_pkg::sample_t sample_out
);

    logic in_fire;

    assign in_fire = in_valid && in_ready;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sample_out))
        else $error("result changed while stalled");

    // the sequencer stays busy with a sample after its input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> ##4 !in_ready)
        else $error("input taken while a sample is in work");

    // a new result appears only as the sequencer returns to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised outside the final step");

endmodule

bind audio_noise_gate ang_checker u_ang_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_ch.valid),
    .in_ready   (sample_ch.ready),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .sample_out (result_ch.sample_out)
);

### sim/testbench.sv
// self-checking testbench of the audio noise gate with a transfer-level scoreboard
`timescale 1ns / 1ps

module testbench;
    import ang_pkg::*;

    localparam longint unsigned Q24_ONE   = 64'd1 << COEF_BITS;
    localparam int              RUN_LIMIT = 400000;
    localparam int              MAX_SHOWN = 10;
    localparam int              TAIL_WAIT = 16;

    // indexes that the block must drop
    localparam cfg_index_t CFG_UNUSED     = cfg_index_t'(4);
    localparam cfg_index_t CFG_UNUSED_TOP = cfg_index_t'(8'hFF);

    // sample shapes of the random part
    typedef enum int {
        SHAPE_HUSH,
        SHAPE_QUIET,
        SHAPE_LOUD,
        SHAPE_EDGE,
        SHAPE_NOISE,
        SHAPE_RAILS,
        SHAPE_FAINT
    } shape_t;

    // expected gated samples, computed from the accepted inputs
    class gate_checker;
        mag_t      thr;
        coef_t     att;
        coef_t     rel;
        coef_t     det;
        mag_t      env;
        gain_t     gain;
        sample_t   gated_due[$];
        int        failures;
        int        seen;

        function new();
            thr      = THRESHOLD_RST;
            att      = ATTACK_RST;
            rel      = RELEASE_RST;
            det      = DETECTOR_RST;
            env      = '0;
            gain     = '0;
            failures = 0;
            seen     = 0;
        endfunction

        // register write as the block takes it, coefficients limited at use
        function void write_reg(cfg_index_t idx, cfg_data_t d);
            case (idx)
                CFG_THRESHOLD: thr = d[SAMPLE_BITS-1:0];
                CFG_ATTACK:    att = d;
                CFG_RELEASE:   rel = d;
                CFG_DETECTOR:  det = d;
                default:       ;
            endcase
        endfunction

        // coefficients above unity act as unity
        function longint unsigned limit_coef(coef_t c);
            return (64'(c) > Q24_ONE) ? Q24_ONE : 64'(c);
        endfunction

        function longint unsigned frac_ceil(longint unsigned a, longint unsigned c);
            if (c == Q24_ONE)
                return a;
            return (a * c + Q24_ONE - 1) >> COEF_BITS;
        endfunction

        function longint unsigned frac_floor(longint unsigned a, longint unsigned c);
            if (c == Q24_ONE)
                return a;
            return (a * c) >> COEF_BITS;
        endfunction

        // envelope, gain and gated output for one accepted sample
        function void take_sample(sample_t s);
            longint unsigned raw;
            longint unsigned m;
            longint unsigned g;
            longint unsigned q;
            longint          r;
            bit              neg;
            raw = 64'(mag_t'(s));
            neg = s[SAMPLE_BITS-1];
            m   = neg ? ((64'd1 << SAMPLE_BITS) - raw) : raw;

            // peak jump or floored decay toward the magnitude
            if (m > 64'(env))
                env = mag_t'(m);
            else
                env = mag_t'(64'(env) - frac_ceil(64'(env) - m, limit_coef(det)));

            // attack toward unity stops one below it, release toward zero
            if (env >= thr) begin
                g    = 64'(gain) + frac_floor(Q24_ONE - 64'(gain), limit_coef(att));
                gain = (g >= Q24_ONE) ? gain_t'(Q24_ONE - 1) : gain_t'(g);
            end
            else begin
                gain = gain_t'(64'(gain) - frac_ceil(64'(gain), limit_coef(rel)));
            end

            // floored scaling, negative side rounds the magnitude up
            if (!neg) begin
                r = longint'((m * 64'(gain)) >> COEF_BITS);
            end
            else begin
                q = (m * 64'(gain) + Q24_ONE - 1) >> COEF_BITS;
                r = -longint'(q);
            end
            gated_due.push_back(sample_t'(r));
        endfunction

        function void note_failure(string msg);
            if (failures < MAX_SHOWN)
                $display("%s", msg);
            failures++;
        endfunction

        // compare one output transfer with the oldest expectation
        function void check_gated(sample_t got);
            sample_t want;
            if (gated_due.size() == 0) begin
                note_failure($sformatf("gated sample %0d: got %0d with nothing outstanding",
                                       seen, got));
            end
            else begin
                want = gated_due.pop_front();
                if (want !== got)
                    note_failure($sformatf("gated sample %0d: expected %0d, got %0d",
                                           seen, want, got));
            end
            seen++;
        endfunction

        function int pending();
            return gated_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ang_in_if  sample_if ();
    ang_out_if result_if ();
    ang_cfg_if cfg_if ();

    gate_checker board;
    int          gap_pct;
    int          stall_pct;
    int          stall_left;
    int          cycle_count;

    audio_noise_gate DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_if),
        .result_ch (result_if),
        .cfg_ch    (cfg_if)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("audio_noise_gate regression: fail");
            $finish;
        end
    end

    // output side, random stall bursts
    initial
    begin
        result_if.ready = 1'b0;
        stall_left      = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < stall_pct) begin
                result_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end
            else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // output transfer monitor
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            board.check_gated(result_if.sample_out);
    end

    // one sample transfer, valid stays high for a following sample
    task automatic push_sample(input sample_t s);
        @(negedge clk);
        sample_if.valid     <= 1'b1;
        sample_if.sample_in <= s;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        board.take_sample(s);
    endtask

    task automatic pause_input(input int n);
        @(negedge clk);
        sample_if.valid <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    // sample with an optional random gap in front
    task automatic play(input int v);
        if ($urandom_range(0, 99) < gap_pct)
            pause_input($urandom_range(1, 19));
        push_sample(sample_t'(v));
    endtask

    // stop the stream and wait for every gated sample
    task automatic drain();
        @(negedge clk);
        sample_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // register write transfer, only while the gate is idle
    task automatic write_reg(input cfg_index_t idx, input cfg_data_t d);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        board.write_reg(idx, d);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // coefficient mix with extremes, values above unity and realistic ranges
    function automatic cfg_data_t pick_coef();
        case ($urandom_range(0, 9))
            0:       return cfg_data_t'(0);
            1:       return cfg_data_t'(1);
            2:       return cfg_data_t'(Q24_ONE - 1);
            3:       return cfg_data_t'(Q24_ONE);
            4:       return cfg_data_t'($urandom_range(Q24_ONE + 1, (1 << CFG_DATA_BITS) - 1));
            5, 6:    return cfg_data_t'($urandom_range(1 << 16, 1 << 20));
            default: return cfg_data_t'($urandom_range(1 << 20, Q24_ONE));
        endcase
    endfunction

    function automatic cfg_data_t pick_threshold();
        case ($urandom_range(0, 7))
            0:       return cfg_data_t'(0);
            1:       return cfg_data_t'($urandom_range(1 << 24, (1 << CFG_DATA_BITS) - 1));
            2:       return cfg_data_t'($urandom_range((1 << 23) + 1, (1 << 24) - 1));
            3:       return cfg_data_t'(1 << 23);
            default: return cfg_data_t'($urandom_range(1 << 10, 1 << 22));
        endcase
    endfunction

    // one sample of a given shape; quiet, edge and faint shapes are scaled around the threshold
    function automatic int make_sample(input shape_t shape, input int thr);
        int amp;
        int v;
        case (shape)
            SHAPE_HUSH:  amp = 16;
            SHAPE_QUIET: amp = thr / 2;
            SHAPE_LOUD:  amp = 1 << 23;
            SHAPE_EDGE:  amp = thr + thr / 8 + 1;
            SHAPE_FAINT: amp = thr / 8 + 1;
            SHAPE_NOISE: return int'(sample_t'($urandom));
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 8388607;
                    1:       return -8388608;
                    2:       return 0;
                    default: return -1;
                endcase
            end
        endcase
        if (amp > (1 << 23))
            amp = 1 << 23;
        v = int'($urandom_range(0, 2 * amp)) - amp;
        if (v > 8388607)
            v = 8388607;
        return v;
    endfunction

    // random settings, then bursts of loud and quiet passages
    task automatic run_phase(input int n_items, input bit calm);
        int     left;
        int     seg;
        int     i;
        shape_t shape;
        write_reg(CFG_THRESHOLD, pick_threshold());
        write_reg(CFG_ATTACK, pick_coef());
        write_reg(CFG_RELEASE, pick_coef());
        write_reg(CFG_DETECTOR, pick_coef());
        stall_pct = calm ? 0 : $urandom_range(5, 25);
        left      = n_items;
        while (left > 0) begin
            seg     = $urandom_range(4, 30);
            shape   = shape_t'($urandom_range(0, 6));
            gap_pct = (calm || $urandom_range(0, 2) == 0) ? 0 : 25;
            for (i = 0; i < seg && left > 0; i++) begin
                play(make_sample(shape, int'(board.thr)));
                left--;
            end
        end
        drain();
    endtask

    // reset, directed cases, random phases, final verdict
    initial
    begin
        int p;
        board               = new();
        cycle_count         = 0;
        gap_pct             = 20;
        stall_pct           = 10;
        rst_n               = 1'b0;
        sample_if.valid     = 1'b0;
        sample_if.sample_in = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register defaults, full scale and small values
        play(8388607);
        play(-8388608);
        play(0);
        play(1);
        play(-1);
        play(4096);
        drain();

        // coefficients at and above unity, dropped indexes
        write_reg(CFG_THRESHOLD, cfg_data_t'(12'hFFF + 1));
        write_reg(CFG_ATTACK, '1);
        write_reg(CFG_RELEASE, cfg_data_t'(Q24_ONE));
        write_reg(CFG_DETECTOR, cfg_data_t'(Q24_ONE + 1));
        write_reg(CFG_UNUSED, '1);
        write_reg(CFG_UNUSED_TOP, '0);
        play(8388607);
        play(8388607);
        play(-8388608);
        play(0);
        play(-100);
        play(4095);
        play(4096);
        drain();

        // threshold above full scale, all coefficients zero
        write_reg(CFG_THRESHOLD, '1);
        write_reg(CFG_ATTACK, '0);
        write_reg(CFG_RELEASE, '0);
        write_reg(CFG_DETECTOR, '0);
        play(-8388608);
        play(8388607);
        play(0);
        play(1);
        drain();

        // gate always open, slowest attack and release, near-unity detector
        write_reg(CFG_THRESHOLD, '0);
        write_reg(CFG_ATTACK, cfg_data_t'(1));
        write_reg(CFG_RELEASE, cfg_data_t'(1));
        write_reg(CFG_DETECTOR, cfg_data_t'(Q24_ONE - 1));
        play(0);
        play(-1);
        play(24'h555555);
        play(int'(sample_t'(24'hAAAAAA)));
        drain();

        // random phases, the last one without idling
        for (p = 0; p < 6; p++)
            run_phase(90, p == 5);

        repeat (TAIL_WAIT)
            @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("audio_noise_gate regression: pass");
        else
            $display("audio_noise_gate regression: fail");
        $finish;
    end

endmodule
